// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, skipped while rst is high.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/lut3d_pkg.sv =====
// Shared constants, types and blend functions of the 3D LUT color mapper.
`timescale 1ns / 1ps

package lut3d_pkg;

  localparam int MAX_GRID   = 33;
  localparam int LUT_DEPTH  = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W     = $clog2(LUT_DEPTH);
  localparam int VAL_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int SIZE_W     = 6;
  localparam int GRID_W     = $clog2(MAX_GRID + 1);
  localparam int POS_W      = $clog2((MAX_GRID - 1) * (2 ** FRAC_W) + 1);
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = (POS_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W      = DIV_STAGES * DIV_BITS;
  localparam int NUM_W      = VAL_W + QUO_W;
  localparam int LOC_LAT    = DIV_STAGES + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = 2 * VAL_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUT_SIZE  = 3'd0,
    REG_MIN_RED   = 3'd1,
    REG_MIN_GREEN = 3'd2,
    REG_MIN_BLUE  = 3'd3,
    REG_MAX_RED   = 3'd4,
    REG_MAX_GREEN = 3'd5,
    REG_MAX_BLUE  = 3'd6
  } reg_index_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP  = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] red;
  } entry_t;

  typedef struct packed {
    logic [GRID_W-1:0] lo;
    logic [GRID_W-1:0] hi;
    logic [FRAC_W-1:0] fr;
  } axis_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fr_red;
    logic [FRAC_W-1:0] fr_green;
    logic [FRAC_W-1:0] fr_blue;
  } frac_t;

  // a*(1-f) + b*f, rounded half up
  function automatic logic [VAL_W-1:0] lerp(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [FRAC_W-1:0] f);
    logic [FRAC_W:0]    wa;
    logic [ACC_W-1:0]   acc;
    wa  = (FRAC_W + 1)'(2 ** FRAC_W) - {1'b0, f};
    acc = ACC_W'(a) * ACC_W'(wa) + ACC_W'(b) * ACC_W'(f) + ACC_W'(2 ** (FRAC_W - 1));
    return acc[FRAC_W +: VAL_W];
  endfunction

  function automatic entry_t lerp_entry(input entry_t a, input entry_t b,
                                        input logic [FRAC_W-1:0] f);
    entry_t r;
    r.red   = lerp(a.red, b.red, f);
    r.green = lerp(a.green, b.green, f);
    r.blue  = lerp(a.blue, b.blue, f);
    return r;
  endfunction

endpackage

// ===== design/lut3d_locate.sv =====
// Per-axis grid locator: domain normalize, pipelined divide, index clamp.
`timescale 1ns / 1ps

module lut3d_locate (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lut3d_pkg::VAL_W-1:0]  value,
  input  logic [lut3d_pkg::VAL_W-1:0]  dom_min,
  input  logic [lut3d_pkg::VAL_W-1:0]  dom_max,
  input  logic [lut3d_pkg::GRID_W-1:0] size,
  output lut3d_pkg::axis_t             axis
);

  localparam int VW = lut3d_pkg::VAL_W;
  localparam int GW = lut3d_pkg::GRID_W;
  localparam int FW = lut3d_pkg::FRAC_W;
  localparam int QW = lut3d_pkg::QUO_W;
  localparam int NW = lut3d_pkg::NUM_W;
  localparam int NS = lut3d_pkg::DIV_STAGES;
  localparam int PW = VW + GW;

  // bits: numerator bits still to shift in on top, quotient bits filling from below
  typedef struct packed {
    logic [VW-1:0] rem;
    logic [QW-1:0] bits;
    logic [VW-1:0] span;
  } div_t;

  function automatic div_t div_step(input div_t d);
    div_t        r;
    logic [VW:0] t;
    r = d;
    for (int i = 0; i < lut3d_pkg::DIV_BITS; i++) begin
      t      = {r.rem, r.bits[QW-1]};
      r.bits = {r.bits[QW-2:0], 1'b0};
      if (t >= {1'b0, r.span}) begin
        t         = t - {1'b0, r.span};
        r.bits[0] = 1'b1;
      end
      r.rem = t[VW-1:0];
    end
    return r;
  endfunction

  logic             empty;
  logic [VW-1:0]    vclamp;
  logic [VW-1:0]    diff;
  logic [VW-1:0]    span;
  logic [GW-1:0]    sm1;
  logic [PW-1:0]    prod;
  logic [NW-1:0]    num;
  div_t             div_in;
  div_t             dq [NS+1];
  logic [QW-1:0]    pos;
  logic [QW-1:0]    lo_full;
  lut3d_pkg::axis_t axis_next;

  always_comb begin
    empty  = (dom_max <= dom_min);
    vclamp = value;
    if (vclamp < dom_min) vclamp = dom_min;
    if (vclamp > dom_max) vclamp = dom_max;
    diff   = vclamp - dom_min;
    span   = dom_max - dom_min;
    sm1    = size - GW'(1);
    prod   = PW'(diff) * PW'(sm1);
    num    = (NW'(prod) << FW) + NW'(span >> 1);
    if (empty) begin
      div_in.rem  = '0;
      div_in.bits = '0;
      div_in.span = VW'(1);
    end else begin
      div_in.rem  = num[NW-1:QW];
      div_in.bits = num[QW-1:0];
      div_in.span = span;
    end
  end

  always_comb begin
    pos     = dq[NS].bits;
    lo_full = pos >> FW;
    if (lo_full >= QW'(sm1)) begin
      axis_next.lo = sm1;
      axis_next.fr = '0;
    end else begin
      axis_next.lo = GW'(lo_full);
      axis_next.fr = pos[FW-1:0];
    end
    axis_next.hi = (axis_next.lo == sm1) ? axis_next.lo : axis_next.lo + GW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0] <= div_in;
      for (int k = 0; k < NS; k++) begin
        dq[k+1] <= div_step(dq[k]);
      end
      axis <= axis_next;
    end
  end

endmodule

// ===== design/lut3d_bank.sv =====
// Table bank: full copy of the LUT with one write port and two registered read ports.
`timescale 1ns / 1ps

module lut3d_bank (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         wr_en,
  input  logic [lut3d_pkg::ADDR_W-1:0] wr_addr,
  input  lut3d_pkg::entry_t            wr_data,
  input  logic [lut3d_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [lut3d_pkg::ADDR_W-1:0] rd_addr_b,
  output lut3d_pkg::entry_t            rd_data_a,
  output lut3d_pkg::entry_t            rd_data_b
);

  lut3d_pkg::entry_t mem [lut3d_pkg::LUT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== design/lut3d_blend.sv =====
// Trilinear blend: red, green, then blue lerps, one register stage each.
`timescale 1ns / 1ps

module lut3d_blend (
  input  logic              clk,
  input  logic              en,
  input  lut3d_pkg::entry_t corner [8],
  input  lut3d_pkg::frac_t  frac,
  output lut3d_pkg::entry_t result
);

  lut3d_pkg::entry_t         c1 [4];
  lut3d_pkg::entry_t         c2 [2];
  logic [lut3d_pkg::FRAC_W-1:0] fg1, fb1, fb2;

  always_ff @(posedge clk) begin
    if (en) begin
      // corner index is {blue, green, red} upper-select bits
      for (int j = 0; j < 4; j++) begin
        c1[j] <= lut3d_pkg::lerp_entry(corner[2*j], corner[2*j+1], frac.fr_red);
      end
      fg1 <= frac.fr_green;
      fb1 <= frac.fr_blue;
      c2[0] <= lut3d_pkg::lerp_entry(c1[0], c1[1], fg1);
      c2[1] <= lut3d_pkg::lerp_entry(c1[2], c1[3], fg1);
      fb2 <= fb1;
      result <= lut3d_pkg::lerp_entry(c2[0], c2[1], fb2);
    end
  end

endmodule

// ===== design/lut3d_trilinear_color_map.sv =====
// Top level of the 3D LUT color mapper with trilinear interpolation.
//
// Input stream s_*: s_tuser[0] selects the item kind (0 load, 1 map).
// A load writes {red, green, blue} at linear index entry_index; indexes at
// or above MAX_GRID^3 are dropped. A map item normalizes each channel to the
// grid, fetches the eight neighbors and returns one blended pixel on m_*.
// Loads return nothing. Config writes (cfg_*) are always accepted and must
// only be issued while no item is in flight.
// Throughput: one item per clock while m_tready does not stall the pipeline;
// the pipeline depth follows DIV_STAGES, the stages of the pipelined
// restoring divider of the normalize step (two quotient bits per stage).
// The eight neighbors come from four table copies with two read ports each.
// A load reaches the table at the same stage where maps read it, so items
// keep their order. Reset clears the pipeline valid bits and the registers
// to lut_size 33, domain 0..65535; table contents are undefined until
// loaded. When m_tready is low with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lut3d_trilinear_color_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // entry_index, red_value, green_value, blue_value
  input  logic [0:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lut3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lut3d_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int VW    = lut3d_pkg::VAL_W;
  localparam int GW    = lut3d_pkg::GRID_W;
  localparam int AW    = lut3d_pkg::ADDR_W;
  localparam int SW    = lut3d_pkg::SIZE_W;
  localparam int P_LOC = lut3d_pkg::LOC_LAT;
  localparam int P_C   = P_LOC + 3;
  localparam int LAST  = P_LOC + 7;

  typedef struct packed {
    logic [VW-1:0]     idx;
    lut3d_pkg::entry_t ent;
  } pay_t;

  logic                 adv;
  logic [SW-1:0]        lut_size;
  logic [VW-1:0]        dom_min [3];
  logic [VW-1:0]        dom_max [3];
  logic [GW-1:0]        s_eff;
  logic [LAST:0]        vld;
  logic [LAST:0]        fn;
  pay_t                 pay [P_C+1];
  lut3d_pkg::axis_t     ax [3];
  logic [AW-1:0]        sb [2];
  logic [GW-1:0]        ra_lo, ra_hi, ga_lo, ga_hi, rb_lo, rb_hi;
  logic [AW-1:0]        tq [4];
  logic [AW-1:0]        addr [8];
  lut3d_pkg::frac_t     frq [4];
  lut3d_pkg::entry_t    corner [8];
  lut3d_pkg::entry_t    result;
  logic                 wr_en;
  logic                 addr_ok;

  assign adv       = !(m_tvalid && !m_tready);
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = vld[LAST] && (fn[LAST] == lut3d_pkg::FUNC_MAP);
  assign m_tdata   = result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lut_size <= SW'(33);
      for (int c = 0; c < 3; c++) begin
        dom_min[c] <= '0;
        dom_max[c] <= '1;
      end
    end else if (cfg_valid) begin
      unique case (lut3d_pkg::reg_index_t'(cfg_index))
        lut3d_pkg::REG_LUT_SIZE:  lut_size   <= cfg_data[SW-1:0];
        lut3d_pkg::REG_MIN_RED:   dom_min[0] <= cfg_data[VW-1:0];
        lut3d_pkg::REG_MIN_GREEN: dom_min[1] <= cfg_data[VW-1:0];
        lut3d_pkg::REG_MIN_BLUE:  dom_min[2] <= cfg_data[VW-1:0];
        lut3d_pkg::REG_MAX_RED:   dom_max[0] <= cfg_data[VW-1:0];
        lut3d_pkg::REG_MAX_GREEN: dom_max[1] <= cfg_data[VW-1:0];
        lut3d_pkg::REG_MAX_BLUE:  dom_max[2] <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(lut_size) < 32'd2) begin
      s_eff = GW'(2);
    end else if (32'(lut_size) > 32'(lut3d_pkg::MAX_GRID)) begin
      s_eff = GW'(lut3d_pkg::MAX_GRID);
    end else begin
      s_eff = GW'(lut_size);
    end
  end

  // item valid and kind travel alongside the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fn         <= {fn[LAST-1:0], s_tuser[0]};
      pay[0].idx <= s_tdata[15:0];
      pay[0].ent <= s_tdata[63:16];
      for (int k = 0; k < P_C; k++) begin
        pay[k+1] <= pay[k];
      end
    end
  end

  lut3d_locate u_loc_red (
    .clk(clk), .en(adv), .value(pay[0].ent.red), .dom_min(dom_min[0]),
    .dom_max(dom_max[0]), .size(s_eff), .axis(ax[0])
  );
  lut3d_locate u_loc_green (
    .clk(clk), .en(adv), .value(pay[0].ent.green), .dom_min(dom_min[1]),
    .dom_max(dom_max[1]), .size(s_eff), .axis(ax[1])
  );
  lut3d_locate u_loc_blue (
    .clk(clk), .en(adv), .value(pay[0].ent.blue), .dom_min(dom_min[2]),
    .dom_max(dom_max[2]), .size(s_eff), .axis(ax[2])
  );

  // address build: s*b, then g + s*b, then r + s*(g + s*b)
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= AW'(s_eff) * AW'(ax[2].lo);
      sb[1] <= AW'(s_eff) * AW'(ax[2].hi);
      ra_lo <= ax[0].lo;
      ra_hi <= ax[0].hi;
      ga_lo <= ax[1].lo;
      ga_hi <= ax[1].hi;
      frq[0] <= '{fr_red: ax[0].fr, fr_green: ax[1].fr, fr_blue: ax[2].fr};
      for (int j = 0; j < 4; j++) begin
        tq[j] <= (j[0] ? AW'(ga_hi) : AW'(ga_lo)) + sb[j >> 1];
      end
      rb_lo  <= ra_lo;
      rb_hi  <= ra_hi;
      frq[1] <= frq[0];
      for (int k = 0; k < 8; k++) begin
        addr[k] <= (k[0] ? AW'(rb_hi) : AW'(rb_lo)) + AW'(s_eff) * tq[k >> 1];
      end
      frq[2] <= frq[1];
      frq[3] <= frq[2];
    end
  end

  assign wr_en = adv && vld[P_C] && (fn[P_C] == lut3d_pkg::FUNC_LOAD) &&
                 ({16'b0, pay[P_C].idx} < 32'(lut3d_pkg::LUT_DEPTH));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    lut3d_bank u_bank (
      .clk(clk), .en(adv), .wr_en(wr_en), .wr_addr(AW'(pay[P_C].idx)),
      .wr_data(pay[P_C].ent), .rd_addr_a(addr[2*b]), .rd_addr_b(addr[2*b+1]),
      .rd_data_a(corner[2*b]), .rd_data_b(corner[2*b+1])
    );
  end

  lut3d_blend u_blend (
    .clk(clk), .en(adv), .corner(corner), .frac(frq[3]), .result(result)
  );

  always_comb begin
    addr_ok = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (32'(addr[k]) >= 32'(lut3d_pkg::LUT_DEPTH)) addr_ok = 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `ASSERT_ON(a_stall_holds, !adv |=> $stable(vld), "pipeline moved during a stall")
  `ASSERT_ON(a_addr_range, (vld[P_C] && fn[P_C] == lut3d_pkg::FUNC_MAP) |-> addr_ok,
             "neighbor address beyond the table")

endmodule
